// ===== rtl/cpnp_pkg.sv =====
// Shared types and constants for the cursor palette nibble painter.
// No dependencies; cpnp_alu and the top level refer to it by scoped names.

package cpnp_pkg;

  // Operation codes carried in the input tuser.
  typedef enum logic [1:0] {
    OP_ADD_COLOR  = 2'd0,
    OP_DRAW_PIXEL = 2'd1,
    OP_FILL_RECT  = 2'd2,
    OP_READ_BYTE  = 2'd3
  } op_e;

  // Result status carried in the output tuser.
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_DUP       = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  // Linear pixel index width: covers y*width + x for 10-bit y/x, 11-bit width.
  localparam int unsigned KW = 23;

  localparam logic [10:0] WIDTH_RESET = 11'd64;
  localparam logic [7:0]  NIB_LO_MASK = 8'h0f;
  localparam logic [7:0]  NIB_HI_MASK = 8'hf0;

  // Shared multiply-add / compare unit request and response.
  typedef struct packed {
    logic [10:0]   mul_a;
    logic [10:0]   mul_b;
    logic [KW-1:0] add_c;
    logic [31:0]   cmp_a;
    logic [31:0]   cmp_b;
  } alu_req_t;

  typedef struct packed {
    logic [KW-1:0] sum;
    logic          eq;
  } alu_rsp_t;

endpackage

// ===== rtl/cpnp_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.

module cpnp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/cpnp_palette.sv =====
// Color palette: entries appended in order, fill count, one indexed read.
// Depends on nothing but its parameter.

module cpnp_palette #(
  parameter int unsigned MAX_COLORS = 16,
  localparam int unsigned CW = $clog2(MAX_COLORS + 1),
  localparam int unsigned IW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [31:0]   wr_color_i,
  input  logic [IW-1:0] rd_idx_i,
  output logic [31:0]   rd_color_o,
  output logic [CW-1:0] count_o
);

  logic [31:0]   entries [MAX_COLORS];
  logic [CW-1:0] count_q;

  // Entries stay undefined until written; searches stop at the count.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entries[count_q[IW-1:0]] <= wr_color_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (wr_en_i) begin
      count_q <= count_q + CW'(1);
    end
  end

  assign rd_color_o = entries[rd_idx_i];
  assign count_o    = count_q;

endmodule

// ===== rtl/cpnp_alu.sv =====
// Shared arithmetic unit: 11x11 multiply plus add, and a 32-bit equality compare.
// Depends on cpnp_pkg.

module cpnp_alu (
  input  cpnp_pkg::alu_req_t req_i,
  output cpnp_pkg::alu_rsp_t rsp_o
);

  logic [21:0] prod;

  assign prod      = 22'(req_i.mul_a) * 22'(req_i.mul_b);
  assign rsp_o.sum = cpnp_pkg::KW'(prod) + req_i.add_c;
  assign rsp_o.eq  = (req_i.cmp_a == req_i.cmp_b);

endmodule

// ===== rtl/cursor_palette_nibble_painter.sv =====
// Cursor palette nibble painter: top level with the sequencer.
// Depends on cpnp_pkg, cpnp_ram, cpnp_palette and cpnp_alu.
//
// Usage:
//   Input stream (s_axis): one transaction per operation, opcode in tuser.
//   Output stream (m_axis): one result transaction per input transaction,
//   status in tuser, palette index and read byte in tdata.
//   cfg_wr_en_i/cfg_wr_data_i load surface_width (pixels per row); the user
//   must write it only while idle; the block itself does not enforce this.
// Steps from acceptance to m_axis_tvalid_o (read byte: a single byte read):
//   add color    search over at most the count + 1 entries, append if new
//   draw pixel   search, address multiply-add, byte read, byte write
//   fill rect    search, address multiply-add, per pixel a byte read and write
// The palette search walks one entry per cycle through the shared compare;
// each pixel is a read-modify-write on the single bitmap RAM.
// One operation is in flight at a time; tready is high only when idle.
// Reset: the bitmap is zeroed by a clearing pass over all STORE_BYTES bytes with
// tready low; the palette count resets to zero and surface_width to 64.
// Output stall: a finished result waits in the output register and the next
// operation is still accepted; its own result waits until that one is taken.

module cursor_palette_nibble_painter #(
  parameter int unsigned MAX_COLORS  = 16,
  parameter int unsigned STORE_BYTES = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_wr_en_i,
  input  logic [10:0] cfg_wr_data_i,   // surface_width
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [87:0] s_axis_tdata_i,  // x_pos[9:0], y_pos[19:10], rect_width[30:20],
                                       // rect_height[41:31], color[73:42],
                                       // byte_address[84:74], zero pad
  input  logic [1:0]  s_axis_tuser_i,  // opcode[1:0]
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // color_index[3:0], read_data[11:4], zero pad
  output logic [1:0]  m_axis_tuser_o   // status[1:0]
);

  localparam int unsigned AW = $clog2(STORE_BYTES);
  localparam int unsigned CW = $clog2(MAX_COLORS + 1);
  localparam int unsigned IW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam int unsigned KW = cpnp_pkg::KW;
  // first linear pixel index whose byte lies outside the bitmap
  localparam logic [KW-1:0] K_LIMIT = KW'(2 * STORE_BYTES);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SEARCH,
    S_ADDR,
    S_FILL_ROW,
    S_PIX_RD,
    S_PIX_WR,
    S_NEXT_ROW,
    S_RD_REQ,
    S_RD_DAT,
    S_FINISH
  } state_e;

  state_e state_q;

  // latched operation
  cpnp_pkg::op_e op_q;
  logic [9:0]    x_q;
  logic [9:0]    y_q;
  logic [10:0]   rw_q;
  logic [10:0]   rh_q;
  logic [31:0]   color_q;
  logic [10:0]   ba_q;

  // walk state
  logic [CW-1:0] srch_q;
  logic [KW-1:0] k_q;      // current pixel
  logic [KW-1:0] k0_q;     // first pixel of current row
  logic [10:0]   row_q;
  logic [10:0]   col_q;
  logic [AW-1:0] clr_q;
  logic [10:0]   width_q;

  // result and output registers
  cpnp_pkg::status_e res_status_q;
  logic [3:0]        res_cidx_q;
  logic [7:0]        res_rdata_q;
  logic              m_valid_q;
  cpnp_pkg::status_e out_status_q;
  logic [3:0]        out_cidx_q;
  logic [7:0]        out_rdata_q;

  // datapath wires
  cpnp_pkg::alu_req_t alu_req;
  cpnp_pkg::alu_rsp_t alu_rsp;
  logic [31:0]        pal_color;
  logic [CW-1:0]      pal_count;
  logic               pal_we;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [7:0]         ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [7:0]         ram_rdata;
  logic               s_accept;
  logic               k_out;
  logic               ba_in_store;
  logic [16:0]        ba_ext;
  logic               srch_end;
  logic               out_load;

  assign s_accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign k_out       = (k_q >= K_LIMIT);
  assign ba_ext      = 17'(ba_q);
  assign ba_in_store = (32'(ba_q) < 32'(STORE_BYTES));
  assign srch_end    = (srch_q == pal_count);
  // finished result moves into the output register when it is free or draining
  assign out_load    = (state_q == S_FINISH) && (!m_valid_q || m_axis_tready_i);

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= cpnp_pkg::WIDTH_RESET;
    end else if (cfg_wr_en_i) begin
      width_q <= cfg_wr_data_i;
    end
  end

  cpnp_palette #(
    .MAX_COLORS (MAX_COLORS)
  ) u_palette (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (pal_we),
    .wr_color_i (color_q),
    .rd_idx_i   (srch_q[IW-1:0]),
    .rd_color_o (pal_color),
    .count_o    (pal_count)
  );

  cpnp_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  cpnp_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared unit operand select
  always_comb begin
    alu_req.cmp_a = pal_color;
    alu_req.cmp_b = color_q;
    alu_req.mul_a = '0;
    alu_req.mul_b = '0;
    alu_req.add_c = k_q;
    unique case (state_q)
      S_ADDR: begin      // y*width + x
        alu_req.mul_a = 11'(y_q);
        alu_req.mul_b = width_q;
        alu_req.add_c = KW'(x_q);
      end
      S_PIX_WR: begin    // next pixel
        alu_req.mul_a = 11'd1;
        alu_req.mul_b = 11'd1;
        alu_req.add_c = k_q;
      end
      S_NEXT_ROW: begin  // next row start
        alu_req.mul_a = 11'd1;
        alu_req.mul_b = width_q;
        alu_req.add_c = k0_q;
      end
      default: begin
      end
    endcase
  end

  // palette append when an add finds no duplicate
  assign pal_we = (state_q == S_SEARCH) && (op_q == cpnp_pkg::OP_ADD_COLOR) && srch_end;

  // bitmap port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = k_q[AW:1];
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = k_q[AW:1];
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
      end
      S_PIX_RD: begin
        ram_re = !k_out;
      end
      S_PIX_WR: begin
        ram_we = 1'b1;
        // even pixel in the high nibble, odd in the low; keep the other
        if (!k_q[0]) begin
          ram_wdata = (ram_rdata & cpnp_pkg::NIB_LO_MASK) | {res_cidx_q, 4'b0000};
        end else begin
          ram_wdata = (ram_rdata & cpnp_pkg::NIB_HI_MASK) | {4'b0000, res_cidx_q};
        end
      end
      S_RD_REQ: begin
        ram_re    = ba_in_store;
        ram_raddr = ba_ext[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      op_q         <= cpnp_pkg::OP_ADD_COLOR;
      x_q          <= '0;
      y_q          <= '0;
      rw_q         <= '0;
      rh_q         <= '0;
      color_q      <= '0;
      ba_q         <= '0;
      srch_q       <= '0;
      k_q          <= '0;
      k0_q         <= '0;
      row_q        <= '0;
      col_q        <= '0;
      clr_q        <= '0;
      res_status_q <= cpnp_pkg::STAT_OK;
      res_cidx_q   <= '0;
      res_rdata_q  <= '0;
      m_valid_q    <= 1'b0;
      out_status_q <= cpnp_pkg::STAT_OK;
      out_cidx_q   <= '0;
      out_rdata_q  <= '0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(STORE_BYTES - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_accept) begin
            op_q         <= cpnp_pkg::op_e'(s_axis_tuser_i);
            x_q          <= s_axis_tdata_i[9:0];
            y_q          <= s_axis_tdata_i[19:10];
            rw_q         <= s_axis_tdata_i[30:20];
            rh_q         <= s_axis_tdata_i[41:31];
            color_q      <= s_axis_tdata_i[73:42];
            ba_q         <= s_axis_tdata_i[84:74];
            srch_q       <= '0;
            row_q        <= '0;
            res_status_q <= cpnp_pkg::STAT_OK;
            res_cidx_q   <= '0;
            res_rdata_q  <= '0;
            unique case (cpnp_pkg::op_e'(s_axis_tuser_i))
              cpnp_pkg::OP_ADD_COLOR: begin
                if (pal_count == CW'(MAX_COLORS)) begin
                  res_status_q <= cpnp_pkg::STAT_FULL;
                  state_q      <= S_FINISH;
                end else begin
                  state_q <= S_SEARCH;
                end
              end
              cpnp_pkg::OP_READ_BYTE: state_q <= S_RD_REQ;
              default:                state_q <= S_SEARCH;
            endcase
          end
        end
        S_SEARCH: begin
          if (srch_end) begin
            if (op_q == cpnp_pkg::OP_ADD_COLOR) begin
              res_cidx_q <= 4'(pal_count);
            end else begin
              res_status_q <= cpnp_pkg::STAT_NOT_FOUND;
            end
            state_q <= S_FINISH;
          end else if (alu_rsp.eq) begin
            if (op_q == cpnp_pkg::OP_ADD_COLOR) begin
              res_status_q <= cpnp_pkg::STAT_DUP;
              state_q      <= S_FINISH;
            end else begin
              res_cidx_q <= 4'(srch_q);
              state_q    <= S_ADDR;
            end
          end else begin
            srch_q <= srch_q + CW'(1);
          end
        end
        S_ADDR: begin
          k0_q <= alu_rsp.sum;
          k_q  <= alu_rsp.sum;
          if (op_q == cpnp_pkg::OP_FILL_RECT) begin
            state_q <= S_FILL_ROW;
          end else begin
            state_q <= S_PIX_RD;
          end
        end
        S_FILL_ROW: begin
          k_q   <= k0_q;
          col_q <= '0;
          if (row_q == rh_q || k0_q >= K_LIMIT) begin
            state_q <= S_FINISH;
          end else if (rw_q == '0) begin
            state_q <= S_NEXT_ROW;
          end else begin
            state_q <= S_PIX_RD;
          end
        end
        S_PIX_RD: begin
          // pixels past the bitmap are dropped; the rest of the row is too
          if (k_out) begin
            state_q <= (op_q == cpnp_pkg::OP_FILL_RECT) ? S_NEXT_ROW : S_FINISH;
          end else begin
            state_q <= S_PIX_WR;
          end
        end
        S_PIX_WR: begin
          k_q   <= alu_rsp.sum;
          col_q <= col_q + 11'd1;
          if (op_q != cpnp_pkg::OP_FILL_RECT) begin
            state_q <= S_FINISH;
          end else if (col_q + 11'd1 == rw_q) begin
            state_q <= S_NEXT_ROW;
          end else begin
            state_q <= S_PIX_RD;
          end
        end
        S_NEXT_ROW: begin
          // zero width would alias every row onto the first, so the fill ends after it
          k0_q  <= alu_rsp.sum;
          row_q <= row_q + 11'd1;
          state_q <= (width_q == '0) ? S_FINISH : S_FILL_ROW;
        end
        S_RD_REQ: begin
          state_q <= ba_in_store ? S_RD_DAT : S_FINISH;
        end
        S_RD_DAT: begin
          res_rdata_q <= ram_rdata;
          state_q     <= S_FINISH;
        end
        S_FINISH: begin
          if (out_load) begin
            out_status_q <= res_status_q;
            out_cidx_q   <= res_cidx_q;
            out_rdata_q  <= res_rdata_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_rdata_q, out_cidx_q};
  assign m_axis_tuser_o  = out_status_q;

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> !s_axis_tready_o)
    else $error("input accepted while an operation is in flight");

  a_fail_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_status_q != cpnp_pkg::STAT_OK) |-> (out_cidx_q == '0 && out_rdata_q == '0))
    else $error("failed result carries a nonzero index or data");

  a_palette_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pal_we |-> (pal_count < CW'(MAX_COLORS)))
    else $error("palette append beyond capacity");

  a_ram_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (32'(ram_waddr) < 32'(STORE_BYTES)))
    else $error("bitmap write outside the store");
`endif

endmodule
